// File: src/lprp_pkg.sv
// Package for the length-prefixed record parser.
// Holds the byte classes, result kinds, error codes, parse phases and the front-to-back item.
// No dependencies.
`default_nettype none
package lprp_pkg;

	localparam int LEN_BITS_DEF = 24;
	localparam int LEN_OUT_W    = 24;
	localparam int REC_W        = 32;
	localparam int QDEPTH       = 4;

	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	typedef enum logic [2:0] {
		CLS_NL    = 3'd0,
		CLS_PLUS  = 3'd1,
		CLS_COMMA = 3'd2,
		CLS_COLON = 3'd3,
		CLS_DASH  = 3'd4,
		CLS_GT    = 3'd5,
		CLS_DIGIT = 3'd6,
		CLS_OTHER = 3'd7
	} cls_t;

	typedef enum logic [2:0] {
		K_HDR  = 3'd0,
		K_KEY  = 3'd1,
		K_VAL  = 3'd2,
		K_REC  = 3'd3,
		K_END  = 3'd4,
		K_ERR  = 3'd5,
		K_HALT = 3'd6
	} kind_t;

	typedef enum logic [2:0] {
		E_NONE = 3'd0,
		E_BAD  = 3'd1,
		E_OVF  = 3'd2,
		E_ZERO = 3'd3,
		E_EOI  = 3'd4
	} err_t;

	typedef enum logic [8:0] {
		PH_START = 9'b000000001,
		PH_KLEN  = 9'b000000010,
		PH_VLEN  = 9'b000000100,
		PH_KEY   = 9'b000001000,
		PH_DASH  = 9'b000010000,
		PH_GT    = 9'b000100000,
		PH_VAL   = 9'b001000000,
		PH_EOL   = 9'b010000000,
		PH_HALT  = 9'b100000000
	} phase_t;

	typedef struct packed {
		logic [7:0] data;
		logic       eoi;
		cls_t       cls;
		logic [3:0] digit;
	} item_t;

endpackage
`default_nettype wire

// File: src/lprp_front.sv
// Front end: takes input beats and classifies each byte for the parse engine.
// Depends on lprp_pkg.
`default_nettype none
module lprp_front (
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	input  wire logic [7:0]       s_tdata,
	input  wire logic             s_tuser,
	input  wire logic             q_full,
	output logic                  push,
	output lprp_pkg::item_t       item
);

	logic [7:0] diff;

	assign diff     = s_tdata - lprp_pkg::CH_ZERO;
	assign s_tready = !q_full;
	assign push     = s_tvalid && !q_full;

	always_comb begin
		item.data  = s_tdata;
		item.eoi   = s_tuser;
		item.digit = diff[3:0];
		priority if (s_tdata == lprp_pkg::CH_NL) begin
			item.cls = lprp_pkg::CLS_NL;
		end else if (s_tdata == lprp_pkg::CH_PLUS) begin
			item.cls = lprp_pkg::CLS_PLUS;
		end else if (s_tdata == lprp_pkg::CH_COMMA) begin
			item.cls = lprp_pkg::CLS_COMMA;
		end else if (s_tdata == lprp_pkg::CH_COLON) begin
			item.cls = lprp_pkg::CLS_COLON;
		end else if (s_tdata == lprp_pkg::CH_DASH) begin
			item.cls = lprp_pkg::CLS_DASH;
		end else if (s_tdata == lprp_pkg::CH_GT) begin
			item.cls = lprp_pkg::CLS_GT;
		end else if (s_tdata >= lprp_pkg::CH_ZERO && s_tdata <= lprp_pkg::CH_NINE) begin
			item.cls = lprp_pkg::CLS_DIGIT;
		end else begin
			item.cls = lprp_pkg::CLS_OTHER;
		end
	end

endmodule
`default_nettype wire

// File: src/lprp_queue.sv
// Short queue of classified bytes between the front end and the parse engine.
// Depends on lprp_pkg.
`default_nettype none
module lprp_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire lprp_pkg::item_t din,
	output logic                 full,
	input  wire logic            pop,
	output logic                 valid,
	output lprp_pkg::item_t      dout
);

	localparam int PTR_W = $clog2(lprp_pkg::QDEPTH);
	localparam int CNT_W = $clog2(lprp_pkg::QDEPTH + 1);

	lprp_pkg::item_t mem_q [lprp_pkg::QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_pop;

	assign full   = (count_q == CNT_W'(lprp_pkg::QDEPTH));
	assign valid  = (count_q != '0);
	assign do_pop = pop && valid;
	assign dout   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (!push && do_pop) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

// File: src/lprp_back.sv
// Parse engine: phase machine, length accumulation and the registered result beat.
// Depends on lprp_pkg.
`default_nettype none
module lprp_back #(
	parameter int LEN_BITS = lprp_pkg::LEN_BITS_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            item_valid,
	input  wire lprp_pkg::item_t item,
	output logic                 pop,
	output logic                 m_tvalid,
	input  wire logic            m_tready,
	output logic [95:0]          m_tdata,
	output logic [2:0]           m_tuser
);

	lprp_pkg::phase_t            phase_q, phase_nxt;
	logic [LEN_BITS-1:0]         key_len_q, key_nxt;
	logic [LEN_BITS-1:0]         val_len_q, val_nxt;
	logic [LEN_BITS-1:0]         bc_q, bc_nxt, bc_inc;
	logic [lprp_pkg::REC_W-1:0]  recs_q, recs_nxt;
	logic [LEN_BITS-1:0]         len_sel;
	logic [LEN_BITS+3:0]         len_wide, acc;
	logic                        ovf;
	lprp_pkg::kind_t             kind;
	lprp_pkg::err_t              err;
	logic [7:0]                  data;

	logic                        m_tvalid_q;
	lprp_pkg::kind_t             kind_q;
	lprp_pkg::err_t              err_q;
	logic [7:0]                  data_q;
	logic [lprp_pkg::LEN_OUT_W-1:0] klen_q, vlen_q;
	logic [lprp_pkg::REC_W-1:0]  rec_q;

	assign pop      = item_valid && (!m_tvalid_q || m_tready);
	assign len_sel  = (phase_q == lprp_pkg::PH_VLEN) ? val_len_q : key_len_q;
	assign len_wide = {4'b0, len_sel};
	assign acc      = (len_wide << 3) + (len_wide << 1) + {{LEN_BITS{1'b0}}, item.digit};
	assign ovf      = |acc[LEN_BITS+3:LEN_BITS];
	assign bc_inc   = bc_q + LEN_BITS'(1);

	always_comb begin
		phase_nxt = phase_q;
		key_nxt   = key_len_q;
		val_nxt   = val_len_q;
		bc_nxt    = bc_q;
		recs_nxt  = recs_q;
		kind      = lprp_pkg::K_HDR;
		err       = lprp_pkg::E_NONE;
		data      = item.data;
		priority if (phase_q == lprp_pkg::PH_HALT) begin
			kind = lprp_pkg::K_HALT;
			data = 8'h00;
		end else if (item.eoi) begin
			phase_nxt = lprp_pkg::PH_HALT;
			kind      = lprp_pkg::K_ERR;
			err       = lprp_pkg::E_EOI;
			data      = 8'h00;
		end else begin
			unique case (phase_q)
				lprp_pkg::PH_START: begin
					if (item.cls == lprp_pkg::CLS_NL) begin
						phase_nxt = lprp_pkg::PH_HALT;
						kind      = lprp_pkg::K_END;
						data      = 8'h00;
					end else if (item.cls == lprp_pkg::CLS_PLUS) begin
						key_nxt   = '0;
						val_nxt   = '0;
						bc_nxt    = '0;
						phase_nxt = lprp_pkg::PH_KLEN;
					end else begin
						phase_nxt = lprp_pkg::PH_HALT;
						kind      = lprp_pkg::K_ERR;
						err       = lprp_pkg::E_BAD;
					end
				end
				lprp_pkg::PH_KLEN, lprp_pkg::PH_VLEN: begin
					if (phase_q == lprp_pkg::PH_KLEN && item.cls == lprp_pkg::CLS_COMMA) begin
						if (key_len_q == '0) begin
							phase_nxt = lprp_pkg::PH_HALT;
							kind      = lprp_pkg::K_ERR;
							err       = lprp_pkg::E_ZERO;
						end else begin
							phase_nxt = lprp_pkg::PH_VLEN;
						end
					end else if (phase_q == lprp_pkg::PH_VLEN &&
							item.cls == lprp_pkg::CLS_COLON) begin
						bc_nxt    = '0;
						phase_nxt = lprp_pkg::PH_KEY;
					end else if (item.cls != lprp_pkg::CLS_DIGIT) begin
						phase_nxt = lprp_pkg::PH_HALT;
						kind      = lprp_pkg::K_ERR;
						err       = lprp_pkg::E_BAD;
					end else if (ovf) begin
						phase_nxt = lprp_pkg::PH_HALT;
						kind      = lprp_pkg::K_ERR;
						err       = lprp_pkg::E_OVF;
					end else if (phase_q == lprp_pkg::PH_KLEN) begin
						key_nxt = acc[LEN_BITS-1:0];
					end else begin
						val_nxt = acc[LEN_BITS-1:0];
					end
				end
				lprp_pkg::PH_KEY: begin
					bc_nxt = bc_inc;
					kind   = lprp_pkg::K_KEY;
					if (bc_inc >= key_len_q) begin
						phase_nxt = lprp_pkg::PH_DASH;
					end
				end
				lprp_pkg::PH_DASH: begin
					if (item.cls == lprp_pkg::CLS_DASH) begin
						phase_nxt = lprp_pkg::PH_GT;
					end else begin
						phase_nxt = lprp_pkg::PH_HALT;
						kind      = lprp_pkg::K_ERR;
						err       = lprp_pkg::E_BAD;
					end
				end
				lprp_pkg::PH_GT: begin
					if (item.cls == lprp_pkg::CLS_GT) begin
						bc_nxt    = '0;
						phase_nxt = (val_len_q == '0) ? lprp_pkg::PH_EOL : lprp_pkg::PH_VAL;
					end else begin
						phase_nxt = lprp_pkg::PH_HALT;
						kind      = lprp_pkg::K_ERR;
						err       = lprp_pkg::E_BAD;
					end
				end
				lprp_pkg::PH_VAL: begin
					bc_nxt = bc_inc;
					kind   = lprp_pkg::K_VAL;
					if (bc_inc >= val_len_q) begin
						phase_nxt = lprp_pkg::PH_EOL;
					end
				end
				lprp_pkg::PH_EOL: begin
					if (item.cls == lprp_pkg::CLS_NL) begin
						recs_nxt  = recs_q + lprp_pkg::REC_W'(1);
						phase_nxt = lprp_pkg::PH_START;
						kind      = lprp_pkg::K_REC;
						data      = 8'h00;
					end else begin
						phase_nxt = lprp_pkg::PH_HALT;
						kind      = lprp_pkg::K_ERR;
						err       = lprp_pkg::E_BAD;
					end
				end
				default: begin
					phase_nxt = lprp_pkg::PH_HALT;
					kind      = lprp_pkg::K_HALT;
					data      = 8'h00;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= lprp_pkg::PH_START;
			key_len_q  <= '0;
			val_len_q  <= '0;
			bc_q       <= '0;
			recs_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (pop) begin
				phase_q    <= phase_nxt;
				key_len_q  <= key_nxt;
				val_len_q  <= val_nxt;
				bc_q       <= bc_nxt;
				recs_q     <= recs_nxt;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			kind_q <= kind;
			err_q  <= err;
			data_q <= data;
			klen_q <= lprp_pkg::LEN_OUT_W'(key_nxt);
			vlen_q <= lprp_pkg::LEN_OUT_W'(val_nxt);
			rec_q  <= recs_nxt;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = kind_q;
	assign m_tdata  = {5'b0, rec_q, err_q, vlen_q, klen_q, data_q};

endmodule
`default_nettype wire

// File: src/length_prefixed_record_parser.sv
// Length-prefixed record parser: one byte per beat in, one result beat out per byte.
// An accepted byte is queued, then the parse engine steps it into the output register.
// Throughput: one byte per cycle while the sink accepts results.
// Four-entry queue between front end and parse engine; output register decouples the sink.
// Reset (arst_n low, asynchronous): queue empty, no result offered, phase at record start,
// lengths and record count zero. After an error or end of dump, results report halted.
// Depends on lprp_pkg, lprp_front, lprp_queue, lprp_back.
`default_nettype none
module length_prefixed_record_parser #(
	parameter int LEN_BITS = lprp_pkg::LEN_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
	input  wire logic        s_tuser,   // [0] end_of_input
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [95:0]      m_tdata,   // [7:0] out_data, [31:8] key_length,
	                                    // [55:32] value_length, [58:56] error_code,
	                                    // [90:59] record_number, [95:91] zero
	output logic [2:0]       m_tuser    // [2:0] out_kind
);

	lprp_pkg::item_t f_item;
	lprp_pkg::item_t q_item;
	logic            push;
	logic            q_full;
	logic            q_valid;
	logic            pop;

	lprp_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_full   (q_full),
		.push     (push),
		.item     (f_item)
	);

	lprp_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (f_item),
		.full   (q_full),
		.pop    (pop),
		.valid  (q_valid),
		.dout   (q_item)
	);

	lprp_back #(
		.LEN_BITS (LEN_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (q_valid),
		.item       (q_item),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser)
	);

endmodule
`default_nettype wire

// File: src/lprp_checker.sv
// Port-level checks for the record parser, bound to the top level.
// Depends on lprp_pkg and length_prefixed_record_parser.
`default_nettype none
module lprp_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [95:0] m_tdata,
	input wire logic [2:0]  m_tuser
);

	logic       in_beat, out_beat, halted_q;
	logic [3:0] pend_q;

	assign in_beat  = s_tvalid && s_tready;
	assign out_beat = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q   <= '0;
			halted_q <= 1'b0;
		end else begin
			pend_q <= pend_q + 4'(in_beat) - 4'(out_beat);
			if (out_beat && (m_tuser == lprp_pkg::K_ERR || m_tuser == lprp_pkg::K_END)) begin
				halted_q <= 1'b1;
			end
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed while stalled");

	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> pend_q != 4'd0 && pend_q <= 4'd5)
		else $error("result without a matching input byte");

	a_halted: assert property (@(posedge clk) disable iff (!arst_n)
		out_beat && halted_q |-> m_tuser == lprp_pkg::K_HALT && m_tdata[7:0] == 8'h00)
		else $error("activity after error or end of dump");

	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == lprp_pkg::K_ERR) == (m_tdata[58:56] != lprp_pkg::E_NONE))
		else $error("error code does not match result kind");

endmodule

bind length_prefixed_record_parser lprp_checker u_lprp_checker (.*);
`default_nettype wire

// File: verif/record_parse_checker.sv
// Checker for the length-prefixed record parser: watches both streams, predicts each result
// beat from the accepted input bytes and compares it field by field.
// Depends on lprp_pkg.
module record_parse_checker
	import lprp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	input  logic              s_tready,
	input  logic [7:0]        s_tdata,
	input  logic              s_tuser,
	input  logic              m_tvalid,
	input  logic              m_tready,
	input  logic [95:0]       m_tdata,
	input  logic [2:0]        m_tuser,
	output int unsigned       fails,
	output int unsigned       pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [31:0] LEN_LIMIT = 32'h00FF_FFFF;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  data;
		logic [23:0] klen;
		logic [23:0] vlen;
		err_t        err;
		logic [31:0] recs;
	} parse_report_t;

	phase_t        parse_phase = PH_START;
	logic [23:0]   klen_acc = '0;
	logic [23:0]   vlen_acc = '0;
	logic [23:0]   bytes_seen = '0;
	logic [31:0]   recs_done = '0;
	parse_report_t parse_reports[$];
	parse_report_t want, got;

	function automatic parse_report_t report(kind_t k, logic [7:0] d, err_t e);
		parse_report_t r;
		r.kind = k;
		r.data = d;
		r.klen = klen_acc;
		r.vlen = vlen_acc;
		r.err  = e;
		r.recs = recs_done;
		return r;
	endfunction

	function automatic parse_report_t abort_with(logic [7:0] d, err_t e);
		parse_phase = PH_HALT;
		return report(K_ERR, d, e);
	endfunction

	function automatic parse_report_t step_parser(logic [7:0] c, logic eoi);
		logic [31:0] grown;
		logic        is_digit;
		is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
		grown = 32'd0;
		if (parse_phase == PH_HALT)
			return report(K_HALT, 8'h00, E_NONE);
		if (eoi)
			return abort_with(8'h00, E_EOI);
		case (parse_phase)
			PH_START: begin
				if (c == CH_NL) begin
					parse_phase = PH_HALT;
					return report(K_END, 8'h00, E_NONE);
				end
				if (c != CH_PLUS)
					return abort_with(c, E_BAD);
				klen_acc = '0;
				vlen_acc = '0;
				bytes_seen = '0;
				parse_phase = PH_KLEN;
				return report(K_HDR, c, E_NONE);
			end
			PH_KLEN: begin
				if (c == CH_COMMA) begin
					if (klen_acc == 0)
						return abort_with(c, E_ZERO);
					parse_phase = PH_VLEN;
					return report(K_HDR, c, E_NONE);
				end
				if (!is_digit)
					return abort_with(c, E_BAD);
				grown = {8'h00, klen_acc} * 32'd10 + {24'h0, c - CH_ZERO};
				if (grown > LEN_LIMIT)
					return abort_with(c, E_OVF);
				klen_acc = grown[23:0];
				return report(K_HDR, c, E_NONE);
			end
			PH_VLEN: begin
				if (c == CH_COLON) begin
					bytes_seen = '0;
					parse_phase = PH_KEY;
					return report(K_HDR, c, E_NONE);
				end
				if (!is_digit)
					return abort_with(c, E_BAD);
				grown = {8'h00, vlen_acc} * 32'd10 + {24'h0, c - CH_ZERO};
				if (grown > LEN_LIMIT)
					return abort_with(c, E_OVF);
				vlen_acc = grown[23:0];
				return report(K_HDR, c, E_NONE);
			end
			PH_KEY: begin
				bytes_seen = bytes_seen + 24'd1;
				if (bytes_seen >= klen_acc)
					parse_phase = PH_DASH;
				return report(K_KEY, c, E_NONE);
			end
			PH_DASH: begin
				if (c != CH_DASH)
					return abort_with(c, E_BAD);
				parse_phase = PH_GT;
				return report(K_HDR, c, E_NONE);
			end
			PH_GT: begin
				if (c != CH_GT)
					return abort_with(c, E_BAD);
				bytes_seen = '0;
				parse_phase = (vlen_acc == 0) ? PH_EOL : PH_VAL;
				return report(K_HDR, c, E_NONE);
			end
			PH_VAL: begin
				bytes_seen = bytes_seen + 24'd1;
				if (bytes_seen >= vlen_acc)
					parse_phase = PH_EOL;
				return report(K_VAL, c, E_NONE);
			end
			PH_EOL: begin
				if (c != CH_NL)
					return abort_with(c, E_BAD);
				recs_done = recs_done + 32'd1;
				parse_phase = PH_START;
				return report(K_REC, 8'h00, E_NONE);
			end
			default: begin
				parse_phase = PH_HALT;
				return report(K_HALT, 8'h00, E_NONE);
			end
		endcase
	endfunction

	task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
		if (exp_val !== act_val) begin
			$error("%s: expected 'h%0h, got 'h%0h", name, exp_val, act_val);
			fails++;
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			parse_phase = PH_START;
			klen_acc = '0;
			vlen_acc = '0;
			bytes_seen = '0;
			recs_done = '0;
			parse_reports.delete();
			fails = 0;
			pending = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.kind = kind_t'(m_tuser);
				got.data = m_tdata[7:0];
				got.klen = m_tdata[31:8];
				got.vlen = m_tdata[55:32];
				got.err  = err_t'(m_tdata[58:56]);
				got.recs = m_tdata[90:59];
				if (parse_reports.size() == 0) begin
					$error("result beat with no byte outstanding: out_kind %0d", m_tuser);
					fails++;
				end else begin
					want = parse_reports.pop_front();
					check_field("out_kind", want.kind, got.kind);
					check_field("out_data", want.data, got.data);
					check_field("key_length", want.klen, got.klen);
					check_field("value_length", want.vlen, got.vlen);
					check_field("error_code", want.err, got.err);
					check_field("record_number", want.recs, got.recs);
				end
			end
			if (s_tvalid && s_tready)
				parse_reports.push_back(step_parser(s_tdata, s_tuser));
			pending = parse_reports.size();
		end
	end

endmodule

// File: verif/tb.sv
// Top of the record parser testbench: clock, reset, byte stimulus and the verdict.
// A dump of directed and random records is fed in, ended by one randomly chosen fault or end.
// Depends on lprp_pkg, length_prefixed_record_parser and record_parse_checker.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import lprp_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int RANDOM_BEATS = 1900;
	localparam logic [7:0] OPENING [22] = '{
		CH_PLUS, 8'h31, CH_COMMA, CH_ZERO, CH_COLON, 8'hFF, CH_DASH, CH_GT, CH_NL,
		CH_PLUS, CH_ZERO, CH_ZERO, 8'h32, CH_COMMA, 8'h31, CH_COLON,
		8'h00, CH_NL, CH_DASH, CH_GT, CH_PLUS, CH_NL
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [95:0] m_tdata;
	logic [2:0]  m_tuser;

	int unsigned fails;
	int unsigned pending;
	int unsigned beats_sent = 0;
	int unsigned quiet_cycles = 0;
	bit          steady = 1'b0;
	logic [7:0]  rec_bytes[$];
	bit          rec_fixed[$];

	always #6 clk = ~clk;

	length_prefixed_record_parser dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	record_parse_checker chk (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.fails    (fails),
		.pending  (pending)
	);

	always @(negedge clk) begin
		m_tready <= steady || ($urandom_range(99) >= 16);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	task automatic put_beat(logic [7:0] b, logic eoi);
		while (!steady && $urandom_range(99) < 16) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tuser <= eoi;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		beats_sent++;
	endtask

	task automatic add_byte(logic [7:0] b, bit fixed);
		rec_bytes.push_back(b);
		rec_fixed.push_back(fixed);
	endtask

	task automatic add_number(int unsigned n, int unsigned zeros);
		string digits;
		digits = $sformatf("%0d", n);
		repeat (zeros) add_byte(CH_ZERO, 1'b1);
		foreach (digits[i]) add_byte(digits[i], 1'b1);
	endtask

	task automatic build_record(int unsigned klen, int unsigned vlen);
		rec_bytes.delete();
		rec_fixed.delete();
		add_byte(CH_PLUS, 1'b1);
		add_number(klen, ($urandom_range(3) == 0) ? $urandom_range(2, 1) : 0);
		add_byte(CH_COMMA, 1'b1);
		add_number(vlen, ($urandom_range(3) == 0) ? $urandom_range(2, 1) : 0);
		add_byte(CH_COLON, 1'b1);
		repeat (klen) add_byte(8'($urandom_range(255)), 1'b0);
		add_byte(CH_DASH, 1'b1);
		add_byte(CH_GT, 1'b1);
		repeat (vlen) add_byte(8'($urandom_range(255)), 1'b0);
		add_byte(CH_NL, 1'b1);
	endtask

	task automatic send_record();
		foreach (rec_bytes[i]) put_beat(rec_bytes[i], 1'b0);
	endtask

	// The block halts for good after a fault or the closing empty line, so one ending per run.
	task automatic end_dump();
		int unsigned cut;
		int unsigned fixed_pos[$];
		logic [7:0]  bad;
		case ($urandom_range(5))
			0: put_beat(CH_NL, 1'b0);
			1: begin
				build_record($urandom_range(6, 1), $urandom_range(6));
				cut = $urandom_range(rec_bytes.size());
				for (int i = 0; i < cut; i++) put_beat(rec_bytes[i], 1'b0);
				put_beat(8'($urandom_range(255)), 1'b1);
			end
			2: begin
				build_record($urandom_range(4, 1), $urandom_range(4));
				foreach (rec_fixed[i]) if (rec_fixed[i]) fixed_pos.push_back(i);
				cut = fixed_pos[$urandom_range(fixed_pos.size() - 1)];
				do bad = 8'($urandom_range(255));
				while (bad inside {CH_NL, CH_PLUS, CH_COMMA, CH_COLON, CH_DASH, CH_GT} ||
				       (bad >= CH_ZERO && bad <= CH_NINE));
				for (int i = 0; i < cut; i++) put_beat(rec_bytes[i], 1'b0);
				put_beat(bad, 1'b0);
			end
			3: begin
				rec_bytes.delete();
				rec_fixed.delete();
				add_byte(CH_PLUS, 1'b1);
				if ($urandom_range(1)) begin
					add_number($urandom_range(20, 1), 0);
					add_byte(CH_COMMA, 1'b1);
				end
				add_number(1677721, $urandom_range(2));
				add_byte(8'(CH_ZERO + $urandom_range(9, 6)), 1'b1);
				send_record();
			end
			4: begin
				put_beat(CH_PLUS, 1'b0);
				repeat ($urandom_range(3)) put_beat(CH_ZERO, 1'b0);
				put_beat(CH_COMMA, 1'b0);
			end
			default: begin
				rec_bytes.delete();
				rec_fixed.delete();
				add_byte(CH_PLUS, 1'b1);
				add_number(24'hFF_FFFF, 0);
				add_byte(CH_COMMA, 1'b1);
				add_number($urandom_range(1) ? 24'hFF_FFFF : 0, 0);
				add_byte(CH_COLON, 1'b1);
				repeat ($urandom_range(30)) add_byte(8'($urandom_range(255)), 1'b0);
				send_record();
				put_beat(8'($urandom_range(255)), 1'b1);
			end
		endcase
	endtask

	initial begin
		int unsigned klen, vlen;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (OPENING[i]) put_beat(OPENING[i], 1'b0);
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);

		while (beats_sent < RANDOM_BEATS) begin
			steady = (beats_sent >= 700) && (beats_sent < 1000);
			klen = ($urandom_range(15) == 0) ? $urandom_range(300, 41) : $urandom_range(12, 1);
			vlen = ($urandom_range(15) == 0) ? $urandom_range(300, 41) : $urandom_range(12);
			build_record(klen, vlen);
			send_record();
		end
		steady = 1'b0;

		end_dump();
		repeat (24) put_beat(8'($urandom_range(255)), 1'($urandom_range(1)));
		s_tvalid <= 1'b0;

		while (pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		if (fails == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
